// ===== rtl/lbh_pkg.sv =====
// Shared types, constants and the byte-to-class fold for the letter bigram histogram.
// No dependencies; the other files, apart from lbh_ifs, refer to it by scoped names.
`default_nettype none
package lbh_pkg;

   localparam int unsigned NUM_CLASSES = 27;
   localparam int unsigned CLASS_BITS = 5;
   localparam int unsigned PAIR_DEPTH = NUM_CLASSES * NUM_CLASSES;
   localparam int unsigned PAIR_ADDR_BITS = $clog2(PAIR_DEPTH);

   localparam logic [CLASS_BITS-1:0] OTHER_CLASS = CLASS_BITS'(NUM_CLASSES - 1);
   localparam logic [CLASS_BITS-1:0] TOTALS_ROW = CLASS_BITS'(NUM_CLASSES);

   localparam logic REQ_FEED = 1'b0;
   localparam logic REQ_READ = 1'b1;

   localparam logic [7:0] LEAD_BYTE = 8'hC3;
   localparam logic [7:0] UPPER_A = 8'd65;
   localparam logic [7:0] UPPER_Z = 8'd90;
   localparam logic [7:0] LOWER_A = 8'd97;
   localparam logic [7:0] LOWER_Z = 8'd122;

   localparam logic [CLASS_BITS-1:0] CLASS_A = 5'd0;
   localparam logic [CLASS_BITS-1:0] CLASS_E = 5'd4;
   localparam logic [CLASS_BITS-1:0] CLASS_I = 5'd8;
   localparam logic [CLASS_BITS-1:0] CLASS_N = 5'd13;
   localparam logic [CLASS_BITS-1:0] CLASS_O = 5'd14;
   localparam logic [CLASS_BITS-1:0] CLASS_U = 5'd20;

   // what the second pipeline stage returns
   localparam logic [1:0] KIND_ZERO = 2'd0;
   localparam logic [1:0] KIND_FEED = 2'd1;
   localparam logic [1:0] KIND_PAIR = 2'd2;
   localparam logic [1:0] KIND_TOTAL = 2'd3;

   typedef struct packed {
      logic issue;
      logic bump;
   } mem_ctl_type;

   function automatic logic [CLASS_BITS-1:0] fold_byte(input logic [7:0] b);
      logic [CLASS_BITS-1:0] c;
      priority if (b >= UPPER_A && b <= UPPER_Z) begin
         c = CLASS_BITS'(b - UPPER_A);
      end else if (b >= LOWER_A && b <= LOWER_Z) begin
         c = CLASS_BITS'(b - LOWER_A);
      end else if (b == 8'h00) begin
         c = CLASS_A;
      end else begin
         unique case (b)
            8'h81, 8'hA1: c = CLASS_A;
            8'h89, 8'hA9: c = CLASS_E;
            8'h8D, 8'hAD: c = CLASS_I;
            8'h91, 8'hB1: c = CLASS_N;
            8'h93, 8'hB3: c = CLASS_O;
            8'h9A, 8'h9C, 8'hBA, 8'hBC: c = CLASS_U;
            default: c = OTHER_CLASS;
         endcase
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/lbh_ifs.sv =====
// Valid/ready channel interfaces for request and response words.
// Depends on nothing; payload widths are fixed.
`default_nettype none
interface lbh_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] byte_value;
   logic [4:0] read_prev;
   logic [4:0] read_next;

   modport source (output valid, req_type, byte_value, read_prev, read_next, input ready);
   modport sink (input valid, req_type, byte_value, read_prev, read_next, output ready);
endinterface

interface lbh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pair_count;
   logic [31:0] char_total;

   modport source (output valid, pair_count, char_total, input ready);
   modport sink (input valid, pair_count, char_total, output ready);
endinterface
`default_nettype wire

// ===== rtl/lbh_count_mem.sv =====
// Counter memory with registered read, saturating write-back and last-write forwarding.
// Depends on lbh_pkg for the control struct.
`default_nettype none
module lbh_count_mem #(
   parameter int unsigned DEPTH = 729,
   parameter int unsigned ADDR_BITS = $clog2(DEPTH),
   parameter int unsigned COUNT_BITS = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire lbh_pkg::mem_ctl_type    ctl,
   input  wire logic [ADDR_BITS-1:0]    addr,
   input  wire logic                    clr_en,
   input  wire logic [ADDR_BITS-1:0]    clr_addr,
   output logic      [COUNT_BITS-1:0]   value
);

   logic [COUNT_BITS-1:0] mem [DEPTH];

   logic [COUNT_BITS-1:0] rd_data_ff;
   logic [ADDR_BITS-1:0]  addr_ff;
   logic                  fwd_valid_ff;
   logic                  fwd_valid_in;
   logic [ADDR_BITS-1:0]  fwd_addr_ff;
   logic [COUNT_BITS-1:0] fwd_data_ff;
   logic [COUNT_BITS-1:0] bumped;

   assign value = (fwd_valid_ff && fwd_addr_ff == addr_ff) ? fwd_data_ff : rd_data_ff;
   assign bumped = (value == '1) ? value : value + COUNT_BITS'(1);

   always_ff @(posedge clock) begin
      if (clr_en) begin
         mem[clr_addr] <= '0;
      end else if (ctl.bump) begin
         mem[addr_ff] <= bumped;
      end
      if (ctl.issue) begin
         rd_data_ff <= mem[addr];
         addr_ff <= addr;
      end
   end

   always_comb begin
      fwd_valid_in = fwd_valid_ff;
      if (clr_en) begin
         fwd_valid_in = 1'b0;
      end else if (ctl.bump) begin
         fwd_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= fwd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.bump && !clr_en) begin
         fwd_addr_ff <= addr_ff;
         fwd_data_ff <= bumped;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/letter_bigram_histogram_core.sv =====
// Top level of the letter bigram histogram: fold, address, pair and class-total memories.
// Depends on lbh_pkg, lbh_ifs (req/rsp channels) and lbh_count_mem.
//
//   channel | dir | handshake   | word
//   req     | in  | valid/ready | req_type, byte_value, read_prev, read_next
//   rsp     | out | valid/ready | pair_count, char_total
//
// One word per cycle sustained while rsp is ready; a response passes the stage 1 and output registers.
// The rate is set by the read-modify-write on the pair memory, one read port and one
// write port, with the previous write forwarded to the next read.
// After reset a sweep zeroes every entry of both memories; req.ready stays low meanwhile.
// A stalled rsp holds the output register, then the stage behind it, then req.
`default_nettype none
module letter_bigram_histogram_core #(
   parameter int unsigned COUNT_BITS = 32
) (
   input  wire logic  clock,
   input  wire logic  reset,
   lbh_req_if.sink    req,
   lbh_rsp_if.source  rsp
);

   localparam int unsigned CB = lbh_pkg::CLASS_BITS;
   localparam int unsigned PAB = lbh_pkg::PAIR_ADDR_BITS;
   localparam logic [PAB-1:0] CLR_LAST = PAB'(lbh_pkg::PAIR_DEPTH - 1);

   logic           clearing_ff, clearing_in;
   logic [PAB-1:0] clr_cnt_ff, clr_cnt_in;
   logic           tot_clr_en;

   logic [CB-1:0]         prev_class_ff, prev_class_in;
   logic [COUNT_BITS-1:0] byte_total_ff, byte_total_in;

   logic          accept;
   logic          s1_adv;
   logic          counted;
   logic [CB-1:0] cls;
   logic          row_ok, col_ok, tot_row;
   logic [1:0]    kind;
   logic [CB-1:0] sel_row, sel_col;
   logic [PAB-1:0] pair_addr;
   logic [CB-1:0]  tot_addr;

   lbh_pkg::mem_ctl_type pair_ctl, tot_ctl;
   logic [COUNT_BITS-1:0] pair_val, tot_val;

   logic                  s1_valid_ff, s1_valid_in;
   logic [1:0]            s1_kind_ff;
   logic [COUNT_BITS-1:0] s1_total_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [31:0]           rsp_pair_ff, rsp_pair_in;
   logic [31:0]           rsp_total_ff;
   logic [COUNT_BITS+31:0] pair_ext, tot_ext, byte_ext;

   // sweep
   always_comb begin
      clearing_in = clearing_ff;
      clr_cnt_in = clr_cnt_ff;
      if (clearing_ff) begin
         clr_cnt_in = clr_cnt_ff + PAB'(1);
         if (clr_cnt_ff == CLR_LAST) begin
            clearing_in = 1'b0;
         end
      end
   end
   assign tot_clr_en = clearing_ff && (clr_cnt_ff < PAB'(lbh_pkg::NUM_CLASSES));

   // stage 0: fold and address
   assign s1_adv = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !clearing_ff && (!s1_valid_ff || s1_adv);
   assign accept = req.valid && req.ready;

   assign cls = lbh_pkg::fold_byte(req.byte_value);
   assign counted = (req.req_type == lbh_pkg::REQ_FEED) && (req.byte_value != lbh_pkg::LEAD_BYTE);
   assign row_ok = req.read_prev < lbh_pkg::TOTALS_ROW;
   assign col_ok = req.read_next < lbh_pkg::TOTALS_ROW;
   assign tot_row = req.read_prev == lbh_pkg::TOTALS_ROW;

   always_comb begin
      priority if (counted) begin
         kind = lbh_pkg::KIND_FEED;
      end else if (req.req_type == lbh_pkg::REQ_READ && col_ok && row_ok) begin
         kind = lbh_pkg::KIND_PAIR;
      end else if (req.req_type == lbh_pkg::REQ_READ && col_ok && tot_row) begin
         kind = lbh_pkg::KIND_TOTAL;
      end else begin
         kind = lbh_pkg::KIND_ZERO;
      end
   end

   assign sel_row = (kind == lbh_pkg::KIND_PAIR) ? req.read_prev : prev_class_ff;
   assign sel_col = (kind == lbh_pkg::KIND_FEED) ? cls : req.read_next;
   assign pair_addr = PAB'(sel_row) * PAB'(lbh_pkg::NUM_CLASSES) + PAB'(sel_col);
   assign tot_addr = sel_col;

   assign pair_ctl.issue = accept && (kind == lbh_pkg::KIND_FEED || kind == lbh_pkg::KIND_PAIR);
   assign tot_ctl.issue = accept && (kind == lbh_pkg::KIND_FEED || kind == lbh_pkg::KIND_TOTAL);
   assign pair_ctl.bump = s1_adv && (s1_kind_ff == lbh_pkg::KIND_FEED);
   assign tot_ctl.bump = pair_ctl.bump;

   always_comb begin
      prev_class_in = prev_class_ff;
      byte_total_in = byte_total_ff;
      if (accept && counted) begin
         prev_class_in = cls;
         if (byte_total_ff != '1) begin
            byte_total_in = byte_total_ff + COUNT_BITS'(1);
         end
      end
   end

   lbh_count_mem #(
      .DEPTH      (lbh_pkg::PAIR_DEPTH),
      .COUNT_BITS (COUNT_BITS)
   ) u_pair_mem (
      .clock    (clock),
      .reset    (reset),
      .ctl      (pair_ctl),
      .addr     (pair_addr),
      .clr_en   (clearing_ff),
      .clr_addr (clr_cnt_ff),
      .value    (pair_val)
   );

   lbh_count_mem #(
      .DEPTH      (lbh_pkg::NUM_CLASSES),
      .COUNT_BITS (COUNT_BITS)
   ) u_tot_mem (
      .clock    (clock),
      .reset    (reset),
      .ctl      (tot_ctl),
      .addr     (tot_addr),
      .clr_en   (tot_clr_en),
      .clr_addr (clr_cnt_ff[CB-1:0]),
      .value    (tot_val)
   );

   // stage 1: select, write back, load output register
   assign pair_ext = {32'd0, pair_val};
   assign tot_ext = {32'd0, tot_val};
   assign byte_ext = {32'd0, s1_total_ff};

   always_comb begin
      unique case (s1_kind_ff)
         lbh_pkg::KIND_PAIR:  rsp_pair_in = pair_ext[31:0];
         lbh_pkg::KIND_TOTAL: rsp_pair_in = tot_ext[31:0];
         default:             rsp_pair_in = 32'd0;
      endcase
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff <= '0;
         prev_class_ff <= lbh_pkg::OTHER_CLASS;
         byte_total_ff <= '0;
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clearing_ff <= clearing_in;
         clr_cnt_ff <= clr_cnt_in;
         prev_class_ff <= prev_class_in;
         byte_total_ff <= byte_total_in;
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff <= kind;
         s1_total_ff <= byte_total_in;
      end
      if (s1_adv) begin
         rsp_pair_ff <= rsp_pair_in;
         rsp_total_ff <= byte_ext[31:0];
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.pair_count = rsp_pair_ff;
   assign rsp.char_total = rsp_total_ff;

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !req.ready)
      else $error("request taken during memory sweep");

   a_sweep_ends: assert property (@(posedge clock) disable iff (reset)
      clearing_ff && clr_cnt_ff == CLR_LAST |=> !clearing_ff)
      else $error("memory sweep did not end at last entry");

   a_total_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> byte_total_ff >= $past(byte_total_ff))
      else $error("byte total decreased");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_kind_ff))
      else $error("stalled stage lost its word");

endmodule
`default_nettype wire

// ===== tb/sv/lbh_checker.sv =====
// Response checker for the letter bigram histogram: tracks the bigram and class tallies
// from accepted request words and compares every response word field by field.
// Depends on lbh_pkg and the lbh_req_if / lbh_rsp_if channel interfaces.
module lbh_checker (
   input  wire logic clock,
   input  wire logic reset,
   lbh_req_if        req,
   lbh_rsp_if        rsp,
   output int        fail_count,
   output int        pending
);

   typedef struct packed {
      logic [31:0] pair_count;
      logic [31:0] char_total;
   } reply_type;

   localparam logic [31:0] COUNT_MAX = '1;

   logic [lbh_pkg::CLASS_BITS-1:0] last_class;
   logic [31:0] bigram_tally [lbh_pkg::NUM_CLASSES][lbh_pkg::NUM_CLASSES];
   logic [31:0] class_tally [lbh_pkg::NUM_CLASSES];
   logic [31:0] bytes_seen;
   reply_type   replies_due [$];

   function automatic logic [lbh_pkg::CLASS_BITS-1:0] letter_class(input logic [7:0] b);
      if (b >= lbh_pkg::UPPER_A && b <= lbh_pkg::UPPER_Z)
         return lbh_pkg::CLASS_BITS'(b - lbh_pkg::UPPER_A);
      if (b >= lbh_pkg::LOWER_A && b <= lbh_pkg::LOWER_Z)
         return lbh_pkg::CLASS_BITS'(b - lbh_pkg::LOWER_A);
      case (b)
         8'h00, 8'h81, 8'hA1:        return lbh_pkg::CLASS_A;
         8'h89, 8'hA9:               return lbh_pkg::CLASS_E;
         8'h8D, 8'hAD:               return lbh_pkg::CLASS_I;
         8'h91, 8'hB1:               return lbh_pkg::CLASS_N;
         8'h93, 8'hB3:               return lbh_pkg::CLASS_O;
         8'h9A, 8'h9C, 8'hBA, 8'hBC: return lbh_pkg::CLASS_U;
         default:                    return lbh_pkg::OTHER_CLASS;
      endcase
   endfunction

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == COUNT_MAX) ? v : v + 32'd1;
   endfunction

   task automatic take_word();
      logic [lbh_pkg::CLASS_BITS-1:0] cls;
      reply_type                      r;
      r.pair_count = '0;
      if (req.req_type == lbh_pkg::REQ_FEED) begin
         if (req.byte_value != lbh_pkg::LEAD_BYTE) begin
            cls = letter_class(req.byte_value);
            bigram_tally[last_class][cls] = sat_inc(bigram_tally[last_class][cls]);
            class_tally[cls] = sat_inc(class_tally[cls]);
            bytes_seen = sat_inc(bytes_seen);
            last_class = cls;
         end
      end else if (req.read_next < lbh_pkg::NUM_CLASSES) begin
         if (req.read_prev < lbh_pkg::NUM_CLASSES) begin
            r.pair_count = bigram_tally[req.read_prev][req.read_next];
         end else if (req.read_prev == lbh_pkg::TOTALS_ROW) begin
            r.pair_count = class_tally[req.read_next];
         end
      end
      r.char_total = bytes_seen;
      replies_due.push_back(r);
   endtask

   task automatic check_reply();
      reply_type want;
      if (replies_due.size() == 0) begin
         $error("unexpected response word: pair_count %0d char_total %0d",
                rsp.pair_count, rsp.char_total);
         fail_count++;
      end else begin
         want = replies_due.pop_front();
         if (rsp.pair_count !== want.pair_count) begin
            $error("pair_count: expected %0d, got %0d", want.pair_count, rsp.pair_count);
            fail_count++;
         end
         if (rsp.char_total !== want.char_total) begin
            $error("char_total: expected %0d, got %0d", want.char_total, rsp.char_total);
            fail_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         last_class = lbh_pkg::OTHER_CLASS;
         for (int i = 0; i < lbh_pkg::NUM_CLASSES; i++) begin
            class_tally[i] = '0;
            for (int j = 0; j < lbh_pkg::NUM_CLASSES; j++) bigram_tally[i][j] = '0;
         end
         bytes_seen = '0;
         replies_due.delete();
         fail_count = 0;
      end else begin
         if (rsp.valid && rsp.ready) check_reply();
         if (req.valid && req.ready) take_word();
      end
      pending = replies_due.size();
   end
endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for letter_bigram_histogram_core: drives request words and response
// back-pressure, and gives the verdict. Depends on lbh_pkg, lbh_ifs and lbh_checker.
module tb_top;

   typedef struct packed {
      logic       req_type;
      logic [7:0] byte_value;
      logic [4:0] read_prev;
      logic [4:0] read_next;
   } word_type;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 240;
   localparam int RANDOM_STEPS = 380;
   localparam logic [7:0] ACCENTED [12] = '{8'h81, 8'hA1, 8'h89, 8'hA9, 8'h8D, 8'hAD,
                                            8'h91, 8'hB1, 8'h93, 8'hB3, 8'h9A, 8'hBC};

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   cycles;
   int   feeds_sent;
   int   reads_sent;
   bit   quiet_send;
   bit   quiet_recv;
   bit   hold_rsp;

   lbh_req_if req ();
   lbh_rsp_if rsp ();

   letter_bigram_histogram_core uut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   lbh_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .rsp        (rsp),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin : watchdog
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic word_type feed_word(input logic [7:0] b);
      word_type w;
      w.req_type   = lbh_pkg::REQ_FEED;
      w.byte_value = b;
      w.read_prev  = 5'($urandom);
      w.read_next  = 5'($urandom);
      return w;
   endfunction

   function automatic word_type read_word(input logic [4:0] row, input logic [4:0] col);
      word_type w;
      w.req_type   = lbh_pkg::REQ_READ;
      w.byte_value = 8'($urandom);
      w.read_prev  = row;
      w.read_next  = col;
      return w;
   endfunction

   task automatic send_word(input word_type w);
      int gap;
      gap = quiet_send ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.req_type   = w.req_type;
      req.byte_value = w.byte_value;
      req.read_prev  = w.read_prev;
      req.read_next  = w.read_next;
      req.valid      = 1'b1;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      @(negedge clock);
      if (w.req_type == lbh_pkg::REQ_FEED) feeds_sent++;
      else reads_sent++;
   endtask

   task automatic send_random();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
         send_word(feed_word(($urandom_range(0, 1) ? lbh_pkg::UPPER_A : lbh_pkg::LOWER_A)
                             + 8'($urandom_range(0, 25))));
      end else if (sel < 52) begin
         send_word(feed_word(lbh_pkg::LEAD_BYTE));
         send_word(feed_word(ACCENTED[$urandom_range(0, 11)]));
      end else if (sel < 58) begin
         send_word(feed_word(8'($urandom_range(32, 64))));
      end else if (sel < 64) begin
         send_word(feed_word(8'($urandom_range(0, 255))));
      end else if (sel < 66) begin
         send_word(feed_word($urandom_range(0, 1) ? lbh_pkg::LEAD_BYTE : 8'h00));
      end else if (sel < 92) begin
         send_word(read_word(5'($urandom_range(0, lbh_pkg::NUM_CLASSES)),
                             5'($urandom_range(0, lbh_pkg::NUM_CLASSES - 1))));
      end else begin
         send_word(read_word(5'($urandom), 5'($urandom)));
      end
   endtask

   initial begin : receiver
      int gap;
      rsp.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end
         gap = quiet_recv ? 0 : $urandom_range(0, 18);
         if (gap > 0) begin
            rsp.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp.ready = 1'b1;
         @(posedge clock);
         while (!rsp.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      reset          = 1'b1;
      req.valid      = 1'b0;
      req.req_type   = lbh_pkg::REQ_FEED;
      req.byte_value = '0;
      req.read_prev  = '0;
      req.read_next  = '0;
      feeds_sent     = 0;
      reads_sent     = 0;
      quiet_send     = 1'b0;
      quiet_recv     = 1'b0;
      hold_rsp       = 1'b0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      send_word(feed_word(lbh_pkg::UPPER_A));
      send_word(feed_word(lbh_pkg::UPPER_Z));
      send_word(feed_word(lbh_pkg::LOWER_A));
      send_word(feed_word(lbh_pkg::LOWER_Z));
      send_word(feed_word(8'h00));
      send_word(feed_word(8'h40));
      send_word(feed_word(8'h5B));
      send_word(feed_word(8'h60));
      send_word(feed_word(8'h7B));
      send_word(feed_word(lbh_pkg::LEAD_BYTE));
      send_word(feed_word(8'hA1));
      send_word(feed_word(8'h9C));
      send_word(feed_word(8'hFF));
      send_word(feed_word(8'h80));
      send_word(read_word(lbh_pkg::OTHER_CLASS, lbh_pkg::CLASS_A));
      send_word(read_word(lbh_pkg::CLASS_A, 5'd25));
      send_word(read_word(lbh_pkg::TOTALS_ROW, lbh_pkg::CLASS_A));
      send_word(read_word(lbh_pkg::TOTALS_ROW, lbh_pkg::OTHER_CLASS));
      send_word(read_word(lbh_pkg::OTHER_CLASS, lbh_pkg::OTHER_CLASS));
      send_word(read_word(5'd28, lbh_pkg::CLASS_A));
      send_word(read_word(5'd31, 5'd31));
      send_word(read_word(lbh_pkg::CLASS_A, 5'd27));
      send_word(read_word(lbh_pkg::TOTALS_ROW, 5'd31));
      send_word(read_word(lbh_pkg::CLASS_A, 5'd31));

      for (int n = 0; n < RANDOM_STEPS; n++) begin
         if (n % 40 == 0) begin
            quiet_send = ($urandom_range(0, 3) == 0);
            quiet_recv = ($urandom_range(0, 3) == 0);
         end
         if (n == 150) begin
            hold_rsp   = 1'b1;
            quiet_send = 1'b1;
         end
         if (n == 300) begin
            req.valid = 1'b0;
            while (pending != 0) @(negedge clock);
         end
         send_random();
      end

      req.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      $display("Run fed %0d text bytes and issued %0d counter reads, with a %0d-cycle",
               feeds_sent, reads_sent, HOLD_CYCLES);
      $display("response stall, a drain pause, and random gaps on both channels.");
      if (fail_count == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
